>>> hw/rtl/rsvm_pkg.sv
// Package for the RBF-kernel SVM decision engine: sizes, command types and the kernel table.
`timescale 1ns / 1ps
package rsvm_pkg;

  localparam int FEATURES    = 6;
  localparam int MAX_SUPPORT = 64;
  localparam int EXP_DEPTH   = 1024;

  localparam int FEAT_W  = 16;
  localparam int WEIGHT_W = 32;
  localparam int GAMMA_W = 24;
  localparam int ICPT_W  = 32;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int SCORE_W = 48;
  localparam int ACC_W   = 50;
  localparam int ADDR_W  = $clog2(MAX_SUPPORT);
  localparam int ROM_AW  = $clog2(EXP_DEPTH);
  localparam int KERN_W  = 17;
  localparam int FRAC_W  = 16;
  localparam int DIST_W  = 35;
  localparam int T_W     = GAMMA_W + DIST_W;
  localparam int ENTRY_W = FEATURES * FEAT_W + WEIGHT_W;
  localparam int IN_W    = ((INDEX_W + FEATURES * FEAT_W + WEIGHT_W + 7) / 8) * 8;
  localparam int OUT_W   = ((SCORE_W + 7) / 8) * 8;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 32;

  localparam logic [CFG_IW-1:0] REG_GAMMA     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_INTERCEPT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_COUNT     = 2'd2;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_CLASSIFY = 1'b1;

  typedef logic [2*KERN_W-1:0] rom_t [EXP_DEPTH];

  typedef struct packed {
    logic               load_we;
    logic               start;
    logic               issue;
    logic [ADDR_W-1:0]  issue_addr;
    logic               out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               pipe_empty;
    logic               out_full;
  } dp_status_t;

  // Long division used only while the table is built at elaboration.
  function automatic logic [63:0] div_small(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Each entry holds the table value at its point and at the next point.
  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] cur;
    logic [63:0] prev;
    a    = 64'd1 << (34 - ROM_AW);
    term = 64'd1 << 30;
    r    = term;
    e    = 64'd1 << 30;
    for (int n = 1; n <= 24; n++) begin
      term = div_small((term * a) >> 30, 64'(n));
      if ((n & 1) == 1) r = r - term;
      else r = r + term;
    end
    prev = (e + (64'd1 << 13)) >> 14;
    for (int n = 1; n <= EXP_DEPTH; n++) begin
      e   = (e * r + (64'd1 << 29)) >> 30;
      cur = (e + (64'd1 << 13)) >> 14;
      rom[n-1] = {prev[KERN_W-1:0], cur[KERN_W-1:0]};
      prev = cur;
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

endpackage

>>> hw/rtl/rbf_svm_decision.sv
// A classify item raises its score once the walk over its support entries has drained
// through the pipeline; count is the support count, at most 64. Items are taken only
// while idle, so a classify item holds off the next item until its score is loaded; the walk
// reads one support entry per cycle into a seven-stage pipeline; load items do not leave idle.
// A score not yet taken holds the next classify item in the drain state until it is taken.
// Reset clears the registers to gamma 1.0, intercept 0, count 0 and idles the controller.
`timescale 1ns / 1ps
module rbf_svm_decision import rsvm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,  // entry_index, feature_0..feature_5, weight, zero pad
  input  logic               s_axis_tuser,  // action
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_W-1:0]   m_axis_tdata,  // score
  output logic               m_axis_tuser   // saturated
);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [SCORE_W-1:0] score;

  rsvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rsvm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_score (score),
    .out_sat   (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_W'(score);

endmodule

>>> hw/rtl/rsvm_ctrl.sv
// Controller state machine: accepts items and sequences the walk over support entries.
`timescale 1ns / 1ps
module rsvm_ctrl import rsvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_action,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [COUNT_W-1:0] cnt, cnt_next;
  logic               accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd.load_we    = 1'b0;
    cmd.start      = 1'b0;
    cmd.issue      = 1'b0;
    cmd.issue_addr = cnt[ADDR_W-1:0];
    cmd.out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.start = 1'b1;
            cnt_next  = '0;
            state_next = (status.count == '0) ? ST_DRAIN : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt_next == status.count) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.pipe_empty && !status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

>>> hw/rtl/rsvm_datapath.sv
// Datapath: support memory, distance lanes, kernel lookup, weighted sum and output register.
`timescale 1ns / 1ps
module rsvm_datapath import rsvm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data,
  input  logic [IN_W-1:0]     in_data,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SCORE_W-1:0]  out_score,
  output logic                out_sat
);

  logic [GAMMA_W-1:0] gamma;
  logic [ICPT_W-1:0]  intercept;
  logic [COUNT_W-1:0] support_count;

  logic [ENTRY_W-1:0] support_mem [MAX_SUPPORT];
  logic [ENTRY_W-1:0] rd_entry;
  logic [FEAT_W-1:0]  x [FEATURES];

  logic [6:0]               v;
  logic [2*FEAT_W:0]        sq [FEATURES];
  logic [WEIGHT_W-1:0]      w2, w3, w4, w5, w6;
  logic [DIST_W-1:0]        d3, d_sum;
  logic [GAMMA_W+17:0]      plo;
  logic [GAMMA_W+16:0]      phi;
  logic [T_W-1:0]           t;
  logic [2*KERN_W-1:0]      rom_q;
  logic [FRAC_W-1:0]        f5;
  logic                     z5;
  logic [KERN_W-1:0]        k_hi, k_lo, k_delta, k6;
  logic [KERN_W+FRAC_W-1:0] k_prod;
  logic [KERN_W-1:0]        k_next;
  logic signed [WEIGHT_W+KERN_W:0] p7;
  logic signed [ACC_W-1:0]  acc;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'({1'b0, {(SCORE_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma         <= GAMMA_W'(65536);
      intercept     <= '0;
      support_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA:     gamma <= cfg_data[GAMMA_W-1:0];
        REG_INTERCEPT: intercept <= cfg_data[ICPT_W-1:0];
        REG_COUNT:     support_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign status.count = (support_count > COUNT_W'(MAX_SUPPORT)) ?
                        COUNT_W'(MAX_SUPPORT) : support_count;
  assign status.pipe_empty = (v == '0);
  assign status.out_full   = out_valid;

  // Support memory: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (cmd.load_we)
      support_mem[in_data[ADDR_W-1:0]] <= in_data[INDEX_W +: ENTRY_W];
    rd_entry <= support_mem[cmd.issue_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int j = 0; j < FEATURES; j++) x[j] <= in_data[INDEX_W + j*FEAT_W +: FEAT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else v <= {v[5:0], cmd.issue};
  end

  // Squared differences, one lane per feature.
  always_ff @(posedge clk) begin
    for (int j = 0; j < FEATURES; j++) begin
      logic signed [FEAT_W:0]     df;
      logic signed [2*FEAT_W+1:0] pr;
      df = $signed({x[j][FEAT_W-1], x[j]}) -
           $signed({rd_entry[j*FEAT_W + FEAT_W-1], rd_entry[j*FEAT_W +: FEAT_W]});
      pr = df * df;
      sq[j] <= pr[2*FEAT_W:0];
    end
    w2 <= rd_entry[FEATURES*FEAT_W +: WEIGHT_W];
  end

  always_comb begin
    d_sum = '0;
    for (int j = 0; j < FEATURES; j++) d_sum = d_sum + DIST_W'(sq[j]);
  end

  // The gamma product is split in two registered partial products, joined in front of the table lookup.
  always_ff @(posedge clk) begin
    d3  <= d_sum;
    w3  <= w2;
    plo <= gamma * d3[17:0];
    phi <= gamma * d3[DIST_W-1:18];
    w4  <= w3;
  end

  assign t = T_W'(plo) + (T_W'(phi) << 18);

  always_ff @(posedge clk) begin
    rom_q <= EXP_ROM[t[35:36-ROM_AW]];
    f5    <= t[36-ROM_AW-1 -: FRAC_W];
    z5    <= |t[T_W-1:36];
    w5    <= w4;
  end

  // Linear interpolation between neighboring table points.
  assign k_hi    = rom_q[2*KERN_W-1:KERN_W];
  assign k_lo    = rom_q[KERN_W-1:0];
  assign k_delta = (k_lo > k_hi) ? (k_lo - k_hi) : (k_hi - k_lo);
  assign k_prod  = k_delta * f5;
  assign k_next  = (k_lo > k_hi) ? (k_hi + k_prod[KERN_W+FRAC_W-1:FRAC_W]) :
                                   (k_hi - k_prod[KERN_W+FRAC_W-1:FRAC_W]);

  always_ff @(posedge clk) begin
    k6 <= z5 ? '0 : k_next;
    w6 <= w5;
    p7 <= $signed(w6) * $signed({1'b0, k6});
  end

  always_ff @(posedge clk) begin
    if (cmd.start) acc <= ACC_W'($signed(intercept));
    else if (v[6]) acc <= acc + ACC_W'(p7 >>> FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (acc > SMAX) begin
        out_score <= SMAX[SCORE_W-1:0];
        out_sat   <= 1'b1;
      end else if (acc < SMIN) begin
        out_score <= SMIN[SCORE_W-1:0];
        out_sat   <= 1'b1;
      end else begin
        out_score <= acc[SCORE_W-1:0];
        out_sat   <= 1'b0;
      end
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the RBF-kernel SVM decision engine.
`timescale 1ns / 1ps
module testbench;
  import rsvm_pkg::*;

  // Register index past the end of the register list.
  localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

  typedef struct {
    bit                 is_cfg;
    logic [CFG_IW-1:0]  reg_sel;
    logic [CFG_DW-1:0]  reg_val;
    logic               act;
    logic [INDEX_W-1:0] idx;
    logic [FEAT_W-1:0]  feat [FEATURES];
    logic [WEIGHT_W-1:0] wt;
    bit                 typed;
    logic [SCORE_W-1:0] typed_score;
  } stim_row_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               sat;
  } decision_t;

  typedef struct {
    bit                 typed;
    logic [SCORE_W-1:0] score;
  } typed_t;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [CFG_IW-1:0]  cfg_index = '0;
  logic [CFG_DW-1:0]  cfg_data = '0;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               s_axis_tuser = 0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               m_axis_tuser;

  rbf_svm_decision dut (.*);

  always #5 clk = ~clk;

  // Predictor state
  longint unsigned exp_tab [EXP_DEPTH+1];
  logic signed [FEAT_W-1:0]   sup_feat [MAX_SUPPORT][FEATURES];
  logic signed [WEIGHT_W-1:0] sup_wt [MAX_SUPPORT];
  longint unsigned gamma_q = 65536;
  longint          icpt_q = 0;
  int              count_q = 0;

  decision_t pending_scores[$];
  typed_t    typed_scores[$];
  stim_row_t dir_rows[$];
  int  errors = 0;
  int  n_loads = 0, n_classify = 0, n_scores = 0;
  longint cycles = 0;
  bit  hold_req = 0, hold_done = 0;
  int  hold_cnt = 0;

  function automatic void fill_exp_table();
    longint unsigned step, term, ratio, e;
    step  = (64'd1 << 34) / EXP_DEPTH;
    term  = 64'd1 << 30;
    ratio = term;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * step) >> 30) / n;
      if (n % 2) ratio -= term;
      else ratio += term;
    end
    e = 64'd1 << 30;
    for (int n = 0; n <= EXP_DEPTH; n++) begin
      if (n > 0) e = (e * ratio + (64'd1 << 29)) >> 30;
      exp_tab[n] = (e + (64'd1 << 13)) >> 14;
    end
  endfunction

  function automatic longint unsigned rbf_kernel(longint unsigned t);
    longint unsigned pos, i, f, hi, lo;
    if (t >= (64'd16 << 32)) return 0;
    pos = (t * EXP_DEPTH) >> 4;
    i = pos >> 32;
    if (i >= EXP_DEPTH) i = EXP_DEPTH - 1;
    f = (pos >> 16) & 64'hFFFF;
    hi = exp_tab[i];
    lo = exp_tab[i+1];
    if (lo > hi) return hi + (((lo - hi) * f) >> 16);
    return hi - (((hi - lo) * f) >> 16);
  endfunction

  function automatic decision_t predict_decision(logic signed [FEAT_W-1:0] x [FEATURES]);
    decision_t       r;
    longint          acc, df, p;
    longint unsigned sq_dist;
    int              n;
    n = (count_q > MAX_SUPPORT) ? MAX_SUPPORT : count_q;
    acc = icpt_q;
    for (int s = 0; s < n; s++) begin
      sq_dist = 0;
      for (int j = 0; j < FEATURES; j++) begin
        df = longint'(x[j]) - longint'(sup_feat[s][j]);
        sq_dist += df * df;
      end
      p = longint'(sup_wt[s]) * longint'(rbf_kernel(gamma_q * sq_dist));
      acc += p >>> 16;
    end
    r.sat = 0;
    if (acc > 64'sh7FFF_FFFF_FFFF) begin
      acc = 64'sh7FFF_FFFF_FFFF;
      r.sat = 1;
    end else if (acc < -64'sh8000_0000_0000) begin
      acc = -64'sh8000_0000_0000;
      r.sat = 1;
    end
    r.score = acc[SCORE_W-1:0];
    return r;
  endfunction

  // Track accepted items and register writes; build expected decisions.
  always @(posedge clk) begin
    logic signed [FEAT_W-1:0] x [FEATURES];
    typed_t    tv;
    decision_t d;
    if (!rst && cfg_we) begin
      case (cfg_index)
        REG_GAMMA:     gamma_q = cfg_data[GAMMA_W-1:0];
        REG_INTERCEPT: icpt_q = longint'($signed(cfg_data[ICPT_W-1:0]));
        REG_COUNT:     count_q = cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      for (int j = 0; j < FEATURES; j++) x[j] = s_axis_tdata[INDEX_W + FEAT_W*j +: FEAT_W];
      if (s_axis_tuser == ACT_LOAD) begin
        for (int j = 0; j < FEATURES; j++) sup_feat[s_axis_tdata[INDEX_W-1:0]][j] = x[j];
        sup_wt[s_axis_tdata[INDEX_W-1:0]] = s_axis_tdata[INDEX_W + FEATURES*FEAT_W +: WEIGHT_W];
        n_loads++;
      end else begin
        d = predict_decision(x);
        tv = typed_scores.pop_front();
        if (tv.typed) begin
          d.score = tv.score;
          d.sat = 0;
        end
        pending_scores.push_back(d);
        n_classify++;
      end
    end
  end

  // Compare every delivered score with the oldest expectation.
  always @(posedge clk) begin
    decision_t d;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_scores++;
      if (pending_scores.size() == 0) begin
        $display("%0t: unexpected score %h", $time, m_axis_tdata[SCORE_W-1:0]);
        errors++;
      end else begin
        d = pending_scores.pop_front();
        if (m_axis_tdata[SCORE_W-1:0] !== d.score) begin
          $display("%0t: score expected %h actual %h", $time, d.score,
                   m_axis_tdata[SCORE_W-1:0]);
          errors++;
        end
        if (m_axis_tuser !== d.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, d.sat, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Result receiver: random stalls, a quiet window, and one long hold-off.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_cnt > 0) begin
      m_axis_tready <= 0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 0;
      hold_cnt <= 400;
      hold_done <= 1;
    end else if (cycles > 30000 && cycles < 60000) begin
      m_axis_tready <= 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic put_item(logic act, logic [INDEX_W-1:0] idx,
                          logic [FEAT_W-1:0] feat [FEATURES], logic [WEIGHT_W-1:0] wt,
                          bit typed, logic [SCORE_W-1:0] typed_score);
    logic [IN_W-1:0] data;
    typed_t tv;
    data = '0;
    data[INDEX_W-1:0] = idx;
    for (int j = 0; j < FEATURES; j++) data[INDEX_W + FEAT_W*j +: FEAT_W] = feat[j];
    data[INDEX_W + FEATURES*FEAT_W +: WEIGHT_W] = wt;
    if (act == ACT_CLASSIFY) begin
      tv.typed = typed;
      tv.score = typed_score;
      typed_scores.push_back(tv);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic sender_gap(bit quiet);
    if (!quiet && $urandom_range(99) < 12) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Registers change only once every pending score has come back.
  task automatic cfg_write(logic [CFG_IW-1:0] sel, logic [CFG_DW-1:0] val);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (MAX_SUPPORT + 20) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic stim_row_t item_row(logic act, logic [INDEX_W-1:0] idx,
                                         logic [FEAT_W-1:0] fv, logic [WEIGHT_W-1:0] wt);
    stim_row_t r;
    r = '{default: '0};
    r.act = act;
    r.idx = idx;
    r.wt = wt;
    for (int j = 0; j < FEATURES; j++) r.feat[j] = fv;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IW-1:0] sel, logic [CFG_DW-1:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.reg_sel = sel;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [FEAT_W-1:0] near_value(logic signed [FEAT_W-1:0] c, int spread);
    int v;
    v = int'(c) + $urandom_range(2*spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[FEAT_W-1:0];
  endfunction

  initial begin
    stim_row_t r;
    logic [FEAT_W-1:0] fv [FEATURES];
    logic [CFG_DW-1:0] g, ic, cn;
    int s;
    bit quiet;
    fill_exp_table();
    repeat (3) @(posedge clk);
    rst <= 0;

    // With no entries in use the score is just the intercept.
    r = item_row(ACT_CLASSIFY, 0, 16'h0000, 0);
    r.typed = 1; r.typed_score = 0;
    dir_rows.push_back(r);
    dir_rows.push_back(cfg_row(REG_INTERCEPT, 32'h0003_0000));
    r = item_row(ACT_CLASSIFY, 6'h3F, 16'hFFFF, 0);
    r.typed = 1; r.typed_score = 48'h3_0000;
    dir_rows.push_back(r);
    dir_rows.push_back(item_row(ACT_LOAD, 0, 16'h7FFF, 32'h7FFF_FFFF));
    dir_rows.push_back(item_row(ACT_LOAD, 1, 16'h8000, 32'h8000_0000));
    dir_rows.push_back(item_row(ACT_LOAD, 2, 16'h0000, 32'h0001_0000));
    dir_rows.push_back(item_row(ACT_LOAD, 3, 16'h0100, 32'hFFFF_0000));
    dir_rows.push_back(cfg_row(REG_INTERCEPT, 32'h0));
    dir_rows.push_back(cfg_row(REG_COUNT, 4));
    dir_rows.push_back(item_row(ACT_CLASSIFY, 0, 16'h0000, 0));
    dir_rows.push_back(item_row(ACT_CLASSIFY, 0, 16'h7FFF, 0));
    dir_rows.push_back(item_row(ACT_CLASSIFY, 0, 16'h8000, 0));
    // Distance right at the edge of the table and just inside it.
    r = item_row(ACT_CLASSIFY, 0, 16'h0000, 0);
    r.feat[0] = 16'd1024;
    dir_rows.push_back(r);
    r.feat[0] = 16'd1023;
    dir_rows.push_back(r);
    dir_rows.push_back(cfg_row(REG_GAMMA, 0));
    dir_rows.push_back(item_row(ACT_CLASSIFY, 0, 16'h1234, 0));
    dir_rows.push_back(cfg_row(REG_GAMMA, 32'h00FF_FFFF));
    dir_rows.push_back(item_row(ACT_CLASSIFY, 0, 16'h0001, 0));
    dir_rows.push_back(cfg_row(REG_NONE, 32'hFFFF_FFFF));
    dir_rows.push_back(item_row(ACT_CLASSIFY, 0, 16'h0100, 0));
    dir_rows.push_back(cfg_row(REG_GAMMA, 32'h0001_0000));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) cfg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
      else put_item(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].feat, dir_rows[i].wt,
                    dir_rows[i].typed, dir_rows[i].typed_score);
    end

    // Fill every support entry so that any count is legal afterwards.
    for (int e = 0; e < MAX_SUPPORT; e++) begin
      for (int j = 0; j < FEATURES; j++)
        fv[j] = ($urandom_range(9) < 8) ? near_value(0, 1024) : FEAT_W'($urandom);
      put_item(ACT_LOAD, INDEX_W'(e), fv, $urandom, 0, 0);
      sender_gap(0);
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin g = 32'h0000_8000; ic = 32'h7FFF_FFFF; cn = 127; end
        1: begin g = 32'h00FF_FFFF; ic = 32'h8000_0000; cn = 64; end
        2: begin g = 0; ic = $urandom; cn = 1; end
        3: begin g = 32'h0001_0000; ic = 0; cn = 0; end
        default: begin
          g = $urandom_range(0, 32'h0003_0000);
          if ($urandom_range(3) == 0) g = $urandom_range(0, 32'h00FF_FFFF);
          ic = $urandom;
          cn = $urandom_range(0, 127);
        end
      endcase
      cfg_write(REG_GAMMA, g);
      cfg_write(REG_INTERCEPT, ic);
      cfg_write(REG_COUNT, cn);
      for (int k = 0; k < 158; k++) begin
        quiet = (ph == 5);
        if (ph == 2 && k == 40) hold_req = 1;
        if ($urandom_range(99) < 25) begin
          for (int j = 0; j < FEATURES; j++)
            fv[j] = ($urandom_range(9) < 8) ? near_value(0, 1024) : FEAT_W'($urandom);
          put_item(ACT_LOAD, INDEX_W'($urandom_range(63)), fv, $urandom, 0, 0);
        end else begin
          // Mostly probe close to a stored entry so the kernel is not zero.
          s = $urandom_range(MAX_SUPPORT - 1);
          for (int j = 0; j < FEATURES; j++)
            fv[j] = ($urandom_range(9) < 7) ? near_value(sup_feat[s][j], 256)
                                            : FEAT_W'($urandom);
          put_item(ACT_CLASSIFY, INDEX_W'($urandom), fv, $urandom, 0, 0);
        end
        sender_gap(quiet);
      end
    end
    s_axis_tvalid <= 0;

    while (pending_scores.size() != 0) @(posedge clk);
    repeat (MAX_SUPPORT + 40) @(posedge clk);
    $display("Covered %0d load and %0d classify items, %0d scores checked, %0d errors.",
             n_loads, n_classify, n_scores, errors);
    $display("Register sweep included gamma 0 and max, intercept extremes, counts 0 to 127.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rsvm_pkg.sv
hw/rtl/rsvm_ctrl.sv
hw/rtl/rsvm_datapath.sv
hw/rtl/rbf_svm_decision.sv
sim/testbench.sv
